[rtl/hfb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfb_pkg
// Shared types, line constants and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package hfb_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_FLAG  = 8'h5E;
    localparam logic [7:0]  ESC_ESC   = 8'h5D;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_TOP   = 16'h8000;

    // one classified frame step, as handed from front to back
    typedef struct packed {
        logic        first;
        logic        pay;
        logic        last;
        logic [7:0]  dst;
        logic [7:0]  src;
        logic [7:0]  cmd;
        logic [7:0]  payload;
        logic [15:0] crc;
    } t_job;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/hfb_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfb_front
// Accepts input beats, tracks the open frame and its CRC, drops beats that
// make no line bytes and queues the rest as jobs for the back end.
// ----------------------------------------------------------------------------
module hfb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_first,
    input  wire logic          i_last,
    input  wire logic          i_has_payload,
    input  wire logic [7:0]    i_dst_addr,
    input  wire logic [7:0]    i_src_addr,
    input  wire logic [7:0]    i_command,
    input  wire logic [7:0]    i_payload_byte,
    output logic               o_q_push,
    output hfb_pkg::t_job      o_q_job
);

    logic        r_in_frame, n_in_frame;
    logic [15:0] r_crc, n_crc;
    logic [15:0] base_crc;
    logic [15:0] job_crc;
    logic        keep;

    always_comb begin
        keep       = i_first || r_in_frame;
        base_crc   = i_first ? hfb_pkg::CRC_INIT : r_crc;
        job_crc    = i_has_payload ? hfb_pkg::crc_byte(base_crc, i_payload_byte) : base_crc;
        n_in_frame = r_in_frame;
        n_crc      = r_crc;
        if (i_accept && keep) begin
            n_in_frame = !i_last;
            n_crc      = i_last ? hfb_pkg::CRC_INIT : job_crc;
        end
        o_q_push = i_accept && keep && (i_first || i_has_payload || i_last);
        o_q_job.first   = i_first;
        o_q_job.pay     = i_has_payload;
        o_q_job.last    = i_last;
        o_q_job.dst     = i_dst_addr;
        o_q_job.src     = i_src_addr;
        o_q_job.cmd     = i_command;
        o_q_job.payload = i_payload_byte;
        o_q_job.crc     = job_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_crc      <= hfb_pkg::CRC_INIT;
        end else begin
            r_in_frame <= n_in_frame;
            r_crc      <= n_crc;
        end
    end

endmodule
`default_nettype wire

[rtl/hfb_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfb_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module hfb_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hfb_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output hfb_pkg::t_job      o_job
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    hfb_pkg::t_job r_mem [DEPTH];
    logic [IW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/hfb_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfb_back
// Walks one job's sections (flag, header, payload, CRC, closing flag), stuffs
// bytes and drives one line byte per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module hfb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire hfb_pkg::t_job i_q_job,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_line_byte,
    output logic               o_run_last,
    output logic               o_frame_end
);

    typedef enum logic [7:0] {
        S_FLAG = 8'b0000_0001,
        S_DST  = 8'b0000_0010,
        S_SRC  = 8'b0000_0100,
        S_CMD  = 8'b0000_1000,
        S_PAY  = 8'b0001_0000,
        S_CLO  = 8'b0010_0000,
        S_CHI  = 8'b0100_0000,
        S_END  = 8'b1000_0000
    } t_seg;

    hfb_pkg::t_job r_job;
    t_seg          r_seg, n_seg, nxt_seg, start_seg;
    logic          r_busy, r_esc, n_esc;
    logic          r_ov;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, r_end, n_end;
    logic [7:0]    cur;
    logic          is_raw, need_esc, can_emit, step, fin, adv;

    always_comb begin
        case (r_seg)
            S_DST:   cur = r_job.dst;
            S_SRC:   cur = r_job.src;
            S_CMD:   cur = r_job.cmd;
            S_PAY:   cur = r_job.payload;
            S_CLO:   cur = r_job.crc[7:0];
            S_CHI:   cur = r_job.crc[15:8];
            default: cur = hfb_pkg::FLAG_BYTE;
        endcase

        fin     = 1'b0;
        nxt_seg = r_seg;
        case (r_seg)
            S_FLAG:  nxt_seg = S_DST;
            S_DST:   nxt_seg = S_SRC;
            S_SRC:   nxt_seg = S_CMD;
            S_CMD: begin
                if (r_job.pay) begin
                    nxt_seg = S_PAY;
                end else if (r_job.last) begin
                    nxt_seg = S_CLO;
                end else begin
                    fin = 1'b1;
                end
            end
            S_PAY: begin
                if (r_job.last) begin
                    nxt_seg = S_CLO;
                end else begin
                    fin = 1'b1;
                end
            end
            S_CLO:   nxt_seg = S_CHI;
            S_CHI:   nxt_seg = S_END;
            default: fin = 1'b1;
        endcase

        if (i_q_job.first) begin
            start_seg = S_FLAG;
        end else if (i_q_job.pay) begin
            start_seg = S_PAY;
        end else begin
            start_seg = S_CLO;
        end

        is_raw   = (r_seg == S_FLAG) || (r_seg == S_END);
        need_esc = !is_raw && !r_esc &&
                   ((cur == hfb_pkg::FLAG_BYTE) || (cur == hfb_pkg::ESC_BYTE));
        can_emit = !r_ov || i_pop;
        step     = r_busy && can_emit;
        adv      = step && !need_esc;

        n_esc = r_esc;
        n_seg = r_seg;
        if (need_esc) begin
            n_byte = hfb_pkg::ESC_BYTE;
        end else if (r_esc) begin
            n_byte = (cur == hfb_pkg::FLAG_BYTE) ? hfb_pkg::ESC_FLAG : hfb_pkg::ESC_ESC;
        end else begin
            n_byte = cur;
        end
        n_end = (r_seg == S_END);
        if (step) begin
            n_esc = need_esc;
            if (adv) begin
                n_seg = nxt_seg;
            end
        end

        o_q_pop = i_q_valid && (!r_busy || (adv && fin));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_esc  <= 1'b0;
            r_seg  <= S_FLAG;
            r_ov   <= 1'b0;
        end else begin
            if (can_emit) begin
                r_ov <= step;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_seg  <= start_seg;
                r_esc  <= 1'b0;
            end else begin
                if (adv && fin) begin
                    r_busy <= 1'b0;
                end
                r_seg <= n_seg;
                r_esc <= n_esc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (can_emit) begin
            r_byte <= n_byte;
            r_last <= adv && fin;
            r_end  <= n_end;
        end
    end

    assign o_empty     = !r_ov;
    assign o_line_byte = r_byte;
    assign o_run_last  = r_last;
    assign o_frame_end = r_end;

endmodule
`default_nettype wire

[rtl/hdlc_frame_builder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_frame_builder
// Byte-stuffing frame builder with a CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// The block sends one line byte per clock while pop keeps up. An input beat
// makes one or two line bytes for its payload byte (two when the byte is
// stuffed), up to fourteen for a beat that opens and closes a frame. The
// output stage, one byte per cycle, sets the pace; the front folds a payload
// byte into the CRC in the cycle it is accepted, and a queue of DEPTH jobs
// lets input beats arrive while earlier bytes are still leaving. Beats that
// make no line bytes are accepted but not queued.
// ----------------------------------------------------------------------------
module hdlc_frame_builder #(
    parameter int DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       i_first,
    input  wire logic       i_last,
    input  wire logic       i_has_payload,
    input  wire logic [7:0] i_dst_addr,
    input  wire logic [7:0] i_src_addr,
    input  wire logic [7:0] i_command,
    input  wire logic [7:0] i_payload_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_line_byte,
    output logic            o_run_last,
    output logic            o_frame_end
);

    logic          q_push, q_pop, q_full, q_valid;
    hfb_pkg::t_job q_in_job, q_out_job;

    assign full = q_full;

    hfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (push && !q_full),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_has_payload  (i_has_payload),
        .i_dst_addr     (i_dst_addr),
        .i_src_addr     (i_src_addr),
        .i_command      (i_command),
        .i_payload_byte (i_payload_byte),
        .o_q_push       (q_push),
        .o_q_job        (q_in_job)
    );

    hfb_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    hfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_out_job),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_line_byte (o_line_byte),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

endmodule
`default_nettype wire

[verif/tb_hdlc_frame_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdlc_frame_builder
// Self-checking bench for the stuffed HDLC frame builder. Input beats are
// queued by a stimulus process and fed by a clocked driver. A line-byte
// predictor tracks the open frame and its CRC-16/CCITT-FALSE, and a clocked
// monitor checks every popped byte against the oldest predicted one. Runs
// directed frames first, then random frames under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_hdlc_frame_builder;

    typedef struct {
        bit       first;
        bit       last;
        bit       pay;
        bit [7:0] dst;
        bit [7:0] src;
        bit [7:0] cmd;
        bit [7:0] data;
    } t_frame_item;

    typedef struct {
        bit [7:0] line_byte;
        bit       run_last;
        bit       frame_end;
    } t_line_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic       i_first = 1'b0;
    logic       i_last = 1'b0;
    logic       i_has_payload = 1'b0;
    logic [7:0] i_dst_addr = 8'h00;
    logic [7:0] i_src_addr = 8'h00;
    logic [7:0] i_command = 8'h00;
    logic [7:0] i_payload_byte = 8'h00;
    logic       full;
    logic       empty;
    logic [7:0] o_line_byte;
    logic       o_run_last;
    logic       o_frame_end;

    t_frame_item pending_items[$];
    t_line_beat  line_expect_q[$];
    bit [15:0]   crc_run = hfb_pkg::CRC_INIT;
    bit          frame_open = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          items_added = 0;
    int          mismatch_count = 0;

    hdlc_frame_builder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_has_payload  (i_has_payload),
        .i_dst_addr     (i_dst_addr),
        .i_src_addr     (i_src_addr),
        .i_command      (i_command),
        .i_payload_byte (i_payload_byte),
        .empty          (empty),
        .pop            (pop),
        .o_line_byte    (o_line_byte),
        .o_run_last     (o_run_last),
        .o_frame_end    (o_frame_end)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit [15:0] crc_ccitt_step(bit [15:0] crc, bit [7:0] b);
        bit [15:0] acc;
        bit        msb;
        acc = crc;
        for (int k = 7; k >= 0; k--) begin
            msb = acc[15] ^ b[k];
            acc = {acc[14:0], 1'b0};
            if (msb) begin
                acc = acc ^ hfb_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void emit_raw(bit [7:0] b, bit is_end);
        t_line_beat lb;
        lb.line_byte = b;
        lb.run_last  = 1'b0;
        lb.frame_end = is_end;
        line_expect_q.push_back(lb);
    endfunction

    function automatic void emit_stuffed(bit [7:0] b);
        if (b == hfb_pkg::FLAG_BYTE) begin
            emit_raw(hfb_pkg::ESC_BYTE, 1'b0);
            emit_raw(hfb_pkg::ESC_FLAG, 1'b0);
        end else if (b == hfb_pkg::ESC_BYTE) begin
            emit_raw(hfb_pkg::ESC_BYTE, 1'b0);
            emit_raw(hfb_pkg::ESC_ESC, 1'b0);
        end else begin
            emit_raw(b, 1'b0);
        end
    endfunction

    function automatic void predict_line_bytes(t_frame_item it);
        int start_sz;
        start_sz = line_expect_q.size();
        if (!it.first && !frame_open) begin
            return;
        end
        if (it.first) begin
            crc_run    = hfb_pkg::CRC_INIT;
            frame_open = 1'b1;
            emit_raw(hfb_pkg::FLAG_BYTE, 1'b0);
            emit_stuffed(it.dst);
            emit_stuffed(it.src);
            emit_stuffed(it.cmd);
        end
        if (it.pay) begin
            emit_stuffed(it.data);
            crc_run = crc_ccitt_step(crc_run, it.data);
        end
        if (it.last) begin
            emit_stuffed(crc_run[7:0]);
            emit_stuffed(crc_run[15:8]);
            emit_raw(hfb_pkg::FLAG_BYTE, 1'b1);
            crc_run    = hfb_pkg::CRC_INIT;
            frame_open = 1'b0;
        end
        if (line_expect_q.size() > start_sz) begin
            line_expect_q[line_expect_q.size() - 1].run_last = 1'b1;
        end
    endfunction

    function automatic bit [7:0] pick_byte();
        if ($urandom_range(3) == 0) begin
            return $urandom_range(1) ? hfb_pkg::FLAG_BYTE : hfb_pkg::ESC_BYTE;
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic add_item(bit first, bit last, bit pay, bit [7:0] dst, bit [7:0] src,
                            bit [7:0] cmd, bit [7:0] data);
        t_frame_item it;
        it.first = first;
        it.last  = last;
        it.pay   = pay;
        it.dst   = dst;
        it.src   = src;
        it.cmd   = cmd;
        it.data  = data;
        pending_items.push_back(it);
        items_added++;
    endtask

    task automatic add_rand_item(bit first, bit last, bit pay);
        add_item(first, last, pay, pick_byte(), pick_byte(), pick_byte(), pick_byte());
    endtask

    task automatic queue_frame();
        int  n;
        bit  split_trailer;
        bit  drop_close;
        n             = ($urandom_range(15) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5);
        split_trailer = ($urandom_range(3) == 0);
        drop_close    = ($urandom_range(7) == 0);
        if ($urandom_range(9) == 0) begin
            add_item(1'b0, 1'($urandom), 1'($urandom), pick_byte(), pick_byte(), pick_byte(),
                     pick_byte());
        end
        if (n == 0) begin
            add_rand_item(1'b1, !drop_close, 1'b0);
            return;
        end
        for (int k = 0; k < n; k++) begin
            add_rand_item(k == 0, (k == n - 1) && !split_trailer && !drop_close, 1'b1);
            if ($urandom_range(9) == 0) begin
                add_rand_item(1'b0, 1'b0, 1'b0);
            end
        end
        if (split_trailer && !drop_close) begin
            add_rand_item(1'b0, 1'b1, 1'b0);
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || push) begin
            @(negedge i_clk);
        end
        while (line_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // feed beats from the pending queue
    always @(posedge i_clk) begin
        t_frame_item it;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                it = pending_items.pop_front();
                push           <= 1'b1;
                i_first        <= it.first;
                i_last         <= it.last;
                i_has_payload  <= it.pay;
                i_dst_addr     <= it.dst;
                i_src_addr     <= it.src;
                i_command      <= it.cmd;
                i_payload_byte <= it.data;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // predict on accepted input beats, check popped line beats
    always @(posedge i_clk) begin
        t_frame_item it;
        t_line_beat  lb;
        if (i_rst_n) begin
            if (push && !full) begin
                it.first = i_first;
                it.last  = i_last;
                it.pay   = i_has_payload;
                it.dst   = i_dst_addr;
                it.src   = i_src_addr;
                it.cmd   = i_command;
                it.data  = i_payload_byte;
                predict_line_bytes(it);
            end
            if (pop && !empty) begin
                if (line_expect_q.size() == 0) begin
                    $error("unexpected line beat: line_byte %h", o_line_byte);
                    mismatch_count++;
                end else begin
                    lb = line_expect_q.pop_front();
                    if (o_line_byte !== lb.line_byte) begin
                        $error("line_byte expected %h got %h", lb.line_byte, o_line_byte);
                        mismatch_count++;
                    end
                    if (o_run_last !== lb.run_last) begin
                        $error("run_last expected %b got %b", lb.run_last, o_run_last);
                        mismatch_count++;
                    end
                    if (o_frame_end !== lb.frame_end) begin
                        $error("frame_end expected %b got %b", lb.frame_end, o_frame_end);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        int target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // stray beats before any frame: dropped
        add_item(1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_item(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        // header with both escape codes, payload extremes
        add_item(1'b1, 1'b0, 1'b0, hfb_pkg::FLAG_BYTE, hfb_pkg::ESC_BYTE, 8'h00, 8'h00);
        add_item(1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'hFF);
        add_item(1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, hfb_pkg::FLAG_BYTE);
        add_item(1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_item(1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, hfb_pkg::ESC_BYTE);
        add_item(1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        // empty frame
        add_item(1'b1, 1'b1, 1'b0, 8'hFF, 8'h00, hfb_pkg::FLAG_BYTE, 8'h00);
        // frame abandoned by a new header
        add_item(1'b1, 1'b0, 1'b1, hfb_pkg::ESC_BYTE, hfb_pkg::FLAG_BYTE,
                 hfb_pkg::ESC_BYTE, hfb_pkg::FLAG_BYTE);
        add_item(1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h5A);
        add_item(1'b1, 1'b0, 1'b1, 8'hAA, 8'h55, 8'hFF, 8'hA5);
        add_item(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        // single-beat frame, open and close together
        add_item(1'b1, 1'b1, 1'b1, 8'h01, 8'h80, 8'hFE, hfb_pkg::ESC_BYTE);
        add_item(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 88;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 88;
                end
                default: begin
                    tx_idle_pct  = 33;
                    rx_stall_pct = 33;
                end
            endcase
            target = items_added + 20;
            while (items_added < target) begin
                queue_frame();
            end
            drain();
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0 && line_expect_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
